### rtl/core/ett_pkg.sv
// Shared types and constants of the expiring token table.
`timescale 1ns / 1ps

package ett_pkg;

    // Number of slots in the table, one cell per slot.
    localparam int ENTRIES = 64;

    localparam int KEY_W  = 128;
    localparam int DOC_W  = 128;
    localparam int HALF_W = 64;
    localparam int TIME_W = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(3600);

    typedef enum logic {
        FUNC_CREATE   = 1'b0,
        FUNC_VALIDATE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_UNAUTH = 2'd2
    } status_t;

    // A request as it walks along the row of cells. Once done is set the
    // remaining cells pass it on untouched.
    typedef struct packed {
        logic              valid;
        func_t             func;
        logic [KEY_W-1:0]  key;
        logic [DOC_W-1:0]  doc;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] expiry;
        logic              done;
        status_t           status;
    } token_t;

endpackage

### rtl/core/ett_if.sv
// Request and response channel interfaces of the expiring token table.
`timescale 1ns / 1ps

interface ett_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] doc_hi;
    logic [63:0] doc_lo;
    logic [31:0] now_secs;

    modport source (output valid, func, key_hi, key_lo, doc_hi, doc_lo, now_secs,
                    input ready);
    modport sink   (input valid, func, key_hi, key_lo, doc_hi, doc_lo, now_secs,
                    output ready);
endinterface

interface ett_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] doc_hi_out;
    logic [63:0] doc_lo_out;

    modport source (output valid, status, doc_hi_out, doc_lo_out, input ready);
    modport sink   (input valid, status, doc_hi_out, doc_lo_out, output ready);
endinterface

### rtl/core/ett_cell.sv
// One table slot: holds an entry and acts on the request passing through it.
`timescale 1ns / 1ps

module ett_cell
    import ett_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  token_t tok_in,
    output token_t tok_out
);

    logic              active_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DOC_W-1:0]  doc_reg;
    logic [TIME_W-1:0] expiry_reg;

    logic expired;
    logic live;
    logic take_create;
    logic take_validate;

    always_comb
    begin
        expired       = expiry_reg < tok_in.now;
        live          = tok_in.valid && !tok_in.done;
        take_create   = live && (tok_in.func == FUNC_CREATE) && (!active_reg || expired);
        take_validate = live && (tok_in.func == FUNC_VALIDATE) && active_reg
                        && (key_reg == tok_in.key);

        tok_out = tok_in;
        if (take_create)
        begin
            tok_out.done   = 1'b1;
            tok_out.status = ST_OK;
            tok_out.doc    = '0;
        end
        else if (take_validate)
        begin
            tok_out.done = 1'b1;
            if (expired)
            begin
                tok_out.status = ST_UNAUTH;
                tok_out.doc    = '0;
            end
            else
            begin
                tok_out.status = ST_OK;
                tok_out.doc    = doc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (en)
        begin
            if (take_create)
            begin
                active_reg <= 1'b1;
            end
            else if (take_validate && expired)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && take_create)
        begin
            key_reg    <= tok_in.key;
            doc_reg    <= tok_in.doc;
            expiry_reg <= tok_in.expiry;
        end
    end

endmodule

### rtl/core/expiring_token_table_top.sv
// Top level of the expiring token table: a row of slot cells with a request walking along it.
`timescale 1ns / 1ps

// The table holds ENTRIES slots, each in a cell of its own that keeps the active
// flag, the 128-bit key, the 128-bit document id and the expiry time. An accepted
// request enters the first cell and moves one cell along the row every cycle; the
// first cell that can serve it (a free or expired slot for a create, the first
// active slot with a matching key for a validate) acts on it and marks it done,
// and later cells pass it on untouched. Because slots are visited in order, the
// lowest-numbered qualifying slot always wins. One request is in flight at a
// time: it passes through the token register in front of every cell in turn and
// is then registered as the response, at the same edge as busy is cleared. The next
// request can be taken at the edge after the previous result has been registered,
// even if that result is still waiting for the consumer, so a request is only
// accepted once the one before it has left the row of cells entirely.
// A stalled response freezes the row once the following request reaches the last
// cell, until the response is taken. The lifetime register resets to 3600 seconds
// and may only be written while no request is in flight. The active flags are
// cleared by reset; the other slot contents are never read before being written.
module expiring_token_table_top
    import ett_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data,
    ett_req_if.sink           req,
    ett_rsp_if.source         rsp
);

    logic [TIME_W-1:0] lifetime_reg;
    logic              busy_reg;
    logic              rsp_valid_reg;
    status_t           rsp_status_reg;
    logic [DOC_W-1:0]  rsp_doc_reg;

    token_t tok_reg [ENTRIES];
    token_t cell_out [ENTRIES];

    logic             accept;
    logic             chain_en;
    token_t           entry_tok;
    logic [TIME_W:0]  expiry_sum;
    token_t           last_tok;
    status_t          final_status;
    logic [DOC_W-1:0] final_doc;
    logic [ENTRIES-1:0] tok_valid_vec;

    // Lifetime register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (cfg_wr_en)
        begin
            lifetime_reg <= cfg_wr_data;
        end
    end

    assign accept    = req.valid && req.ready;
    assign req.ready = !busy_reg;

    // The row advances unless the result would land on an output register that
    // still holds an untaken response.
    assign chain_en = !(tok_reg[ENTRIES-1].valid && rsp_valid_reg && !rsp.ready);

    // Build the request as it enters the row. The expiry saturates at the
    // largest time value. A validate with a zero key is settled at once as
    // unauthorised and simply rides along the row.
    always_comb
    begin
        expiry_sum       = {1'b0, req.now_secs} + {1'b0, lifetime_reg};
        entry_tok.valid  = 1'b1;
        entry_tok.func   = func_t'(req.func);
        entry_tok.key    = {req.key_hi, req.key_lo};
        entry_tok.doc    = {req.doc_hi, req.doc_lo};
        entry_tok.now    = req.now_secs;
        entry_tok.expiry = expiry_sum[TIME_W] ? TIME_MAX : expiry_sum[TIME_W-1:0];
        entry_tok.done   = (req.func == FUNC_VALIDATE) && ({req.key_hi, req.key_lo} == '0);
        entry_tok.status = ST_UNAUTH;
    end

    // Row of cells with a token register in front of each.
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            ett_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (chain_en),
                .tok_in  (tok_reg[gi]),
                .tok_out (cell_out[gi])
            );

            assign tok_valid_vec[gi] = tok_reg[gi].valid;

            if (gi == 0)
            begin : g_head
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        tok_reg[gi].valid <= 1'b0;
                    end
                    else if (accept)
                    begin
                        tok_reg[gi] <= entry_tok;
                    end
                    else if (chain_en)
                    begin
                        tok_reg[gi].valid <= 1'b0;
                    end
                end
            end
            else
            begin : g_link
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        tok_reg[gi].valid <= 1'b0;
                    end
                    else if (chain_en)
                    begin
                        tok_reg[gi] <= cell_out[gi-1];
                    end
                end
            end
        end
    endgenerate

    // A request that no cell took ends as table full for a create and as
    // unauthorised for a validate. Only a successful validate carries a
    // document id out.
    always_comb
    begin
        last_tok = cell_out[ENTRIES-1];
        if (last_tok.done)
        begin
            final_status = last_tok.status;
        end
        else if (last_tok.func == FUNC_CREATE)
        begin
            final_status = ST_FULL;
        end
        else
        begin
            final_status = ST_UNAUTH;
        end
        final_doc = (last_tok.done && (last_tok.status == ST_OK)) ? last_tok.doc : '0;
    end

    // Busy flag and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tok_reg[ENTRIES-1].valid && chain_en)
            begin
                busy_reg <= 1'b0;
            end

            if (tok_reg[ENTRIES-1].valid && chain_en)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_reg[ENTRIES-1].valid && chain_en)
        begin
            rsp_status_reg <= final_status;
            rsp_doc_reg    <= final_doc;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.doc_hi_out = rsp_doc_reg[DOC_W-1:HALF_W];
    assign rsp.doc_lo_out = rsp_doc_reg[HALF_W-1:0];

    // At most one request is ever walking along the row.
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one request in the row of cells");

    // An idle block has nothing in the row.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (tok_valid_vec == '0))
        else $error("request in the row while the block is idle");

    // A request leaving the last cell is registered as a response and frees the block.
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_reg[ENTRIES-1].valid && chain_en) |=> (rsp_valid_reg && !busy_reg))
        else $error("result leaving the row was not registered");

    // A response never carries an unused status code.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_status_reg == ST_OK || rsp_status_reg == ST_FULL
                           || rsp_status_reg == ST_UNAUTH))
        else $error("response with an unused status code");

endmodule

### bench/ett_reply_checker.sv
// Reply checker for the expiring token table: predicts every reply and compares it.
`timescale 1ns / 1ps

module ett_reply_checker
    import ett_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [TIME_W-1:0] cfg_wr_data,
    ett_req_if                req,
    ett_rsp_if                rsp,
    output int                mismatches,
    output int                outstanding
);

    typedef struct {
        status_t           status;
        logic [HALF_W-1:0] doc_hi;
        logic [HALF_W-1:0] doc_lo;
        int                serial;
    } token_reply_t;

    logic              slot_live   [ENTRIES];
    logic [KEY_W-1:0]  slot_key    [ENTRIES];
    logic [DOC_W-1:0]  slot_doc    [ENTRIES];
    logic [TIME_W-1:0] slot_expiry [ENTRIES];
    logic [TIME_W-1:0] lifetime;
    token_reply_t      owed_replies[$];
    token_reply_t      predicted;
    int                req_serial;
    int                rsp_serial;
    int                n_bad = 0;

    assign mismatches = n_bad;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_bad++;
    endtask

    // Applies one request to the shadow table and returns the reply it should give.
    function automatic token_reply_t resolve_token_request(
        input func_t             op,
        input logic [KEY_W-1:0]  key,
        input logic [DOC_W-1:0]  doc,
        input logic [TIME_W-1:0] now
    );
        token_reply_t      r;
        logic [TIME_W:0]   sum;
        int                slot;
        r.status = ST_OK;
        r.doc_hi = '0;
        r.doc_lo = '0;
        r.serial = 0;
        slot     = -1;
        if (op == FUNC_CREATE)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!slot_live[i] || slot_expiry[i] < now)
                begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                sum                = {1'b0, now} + {1'b0, lifetime};
                slot_key[slot]     = key;
                slot_doc[slot]     = doc;
                slot_expiry[slot]  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                slot_live[slot]    = 1'b1;
            end
        end
        else
        begin
            r.status = ST_UNAUTH;
            if (key != '0)
            begin
                // Only the lowest matching live slot is looked at.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_live[i] && slot_key[i] == key)
                    begin
                        if (slot_expiry[i] < now)
                        begin
                            slot_live[i] = 1'b0;
                        end
                        else
                        begin
                            r.status = ST_OK;
                            r.doc_hi = slot_doc[i][DOC_W-1:HALF_W];
                            r.doc_lo = slot_doc[i][HALF_W-1:0];
                        end
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_reply();
        token_reply_t want;
        if (owed_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply %0d arrived with no request outstanding",
                                      rsp_serial));
        end
        else
        begin
            want = owed_replies.pop_front();
            if (rsp.status !== want.status)
                report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                          want.serial, rsp.status, want.status));
            if (rsp.doc_hi_out !== want.doc_hi)
                report_mismatch($sformatf("reply %0d doc_hi_out %h, expected %h",
                                          want.serial, rsp.doc_hi_out, want.doc_hi));
            if (rsp.doc_lo_out !== want.doc_lo)
                report_mismatch($sformatf("reply %0d doc_lo_out %h, expected %h",
                                          want.serial, rsp.doc_lo_out, want.doc_lo));
        end
        rsp_serial++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_live[i] = 1'b0;
            lifetime = LIFETIME_RESET;
            owed_replies.delete();
            req_serial = 0;
            rsp_serial = 0;
            outstanding <= 0;
        end
        else
        begin
            // A request taken at this edge cannot have its reply out yet, so replies go first.
            if (rsp.valid && rsp.ready)
                check_reply();
            if (cfg_wr_en)
                lifetime = cfg_wr_data;
            if (req.valid && req.ready)
            begin
                predicted = resolve_token_request(func_t'(req.func),
                                                  {req.key_hi, req.key_lo},
                                                  {req.doc_hi, req.doc_lo},
                                                  req.now_secs);
                predicted.serial = req_serial;
                req_serial++;
                owed_replies.push_back(predicted);
            end
            outstanding <= owed_replies.size();
        end
    end

endmodule

### bench/tb_top.sv
// Top of the expiring token table testbench: clock, reset, request and reply traffic, verdict.
`timescale 1ns / 1ps

// The bench drives create and validate requests into the table and takes the replies
// with a consumer that stalls at random. Every request gives exactly one reply, and the
// table works on one request at a time, so the run is paced by the walk along the row
// of slots. The reply checker beside the block keeps its own copy of the table and
// reports any reply that differs; this module only makes traffic and reads the
// checker's counters at the end.
module tb_top;
    import ett_pkg::*;

    // Number of cycles the consumer refuses replies during the back-pressure phase.
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 70;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;
    int                mismatches;
    int                outstanding;

    // When calm is set neither side idles, giving back-to-back stretches.
    bit                calm;
    // Raised by the stimulus to ask the consumer for one long stall.
    bit                hold_replies;
    // Notional wall clock in seconds; most requests carry it as their time stamp.
    logic [TIME_W-1:0] clock_secs;
    // Keys created so far, so that validates can actually hit something.
    logic [KEY_W-1:0]  known_keys[$];

    ett_req_if req_ch();
    ett_rsp_if rsp_ch();

    expiring_token_table_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    ett_reply_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run, including the long consumer stall.
    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one request after a random gap and returns at the edge where it is taken.
    // If there is no gap, valid simply stays high and only the payload changes.
    task automatic send_request(input func_t op, input logic [KEY_W-1:0] key,
                                input logic [DOC_W-1:0] doc, input logic [TIME_W-1:0] now);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.key_hi   <= key[KEY_W-1:HALF_W];
        req_ch.key_lo   <= key[HALF_W-1:0];
        req_ch.doc_hi   <= doc[DOC_W-1:HALF_W];
        req_ch.doc_lo   <= doc[HALF_W-1:0];
        req_ch.now_secs <= now;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Stops offering and waits until every reply owed has been taken. The checker's
    // count is updated at the clock edge, so it is only trusted from the next edge on.
    task automatic wait_until_settled();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Writes the lifetime register; only called while the table is idle.
    task automatic set_lifetime(input logic [TIME_W-1:0] secs);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= secs;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random request. Creates mostly use fresh keys, sometimes a key already in the
    // table (duplicates) or the zero key. Validates mostly use known keys so that hits,
    // expiries and deactivations are common; the rest are zero keys, unknown keys and
    // keys that match a stored one in only one half.
    task automatic send_random_request(input int create_share);
        int                pick;
        int                flavour;
        logic [KEY_W-1:0]  key;
        logic [DOC_W-1:0]  doc;
        logic [TIME_W-1:0] now;
        clock_secs = clock_secs + TIME_W'($urandom_range(0, 20));
        now        = ($urandom_range(0, 99) < 3) ? TIME_W'($urandom) : clock_secs;
        flavour    = $urandom_range(0, 19);
        doc        = (flavour == 0) ? '0 : (flavour == 1) ? '1 : {rand64(), rand64()};
        pick       = $urandom_range(0, 99);
        flavour    = $urandom_range(0, 99);
        if (pick < create_share)
        begin
            if (flavour < 12 && known_keys.size() > 0)
            begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            else if (flavour < 15)
            begin
                key = '0;
            end
            else
            begin
                // A nonzero key with one half zero now and then.
                if (flavour < 22)
                    key = {64'h0, rand64() | 64'h1};
                else if (flavour < 29)
                    key = {rand64() | 64'h1, 64'h0};
                else
                    key = {rand64(), rand64()};
                known_keys.push_back(key);
                if (known_keys.size() > 20)
                    known_keys.delete($urandom_range(0, known_keys.size() - 1));
            end
            send_request(FUNC_CREATE, key, doc, now);
        end
        else
        begin
            if (known_keys.size() == 0 || (flavour >= 75 && flavour < 92))
            begin
                key = {rand64(), rand64()};
            end
            else if (flavour < 75)
            begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            else if (flavour < 96)
            begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                key[HALF_W-1:0] = ~key[HALF_W-1:0];
            end
            else
            begin
                key = '0;
            end
            send_request(FUNC_VALIDATE, key, doc, now);
        end
    endtask

    // Reply consumer. It stalls for a random number of cycles before each reply unless
    // calm is set, and performs the long stall once when asked. The long stall is timed
    // here, so the producer keeps offering requests while the table backs up.
    initial
    begin
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_replies)
            begin
                hold_replies = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm)
            begin
                int stall;
                stall = $urandom_range(0, 9);
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Main stimulus: reset, a directed opening, then phases with different lifetimes.
    initial
    begin
        logic [KEY_W-1:0]  key_a;
        logic [KEY_W-1:0]  key_c;
        logic [TIME_W-1:0] lifetime;
        int                create_share;
        int                settle;

        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_CREATE;
        req_ch.key_hi   = '0;
        req_ch.key_lo   = '0;
        req_ch.doc_hi   = '0;
        req_ch.doc_lo   = '0;
        req_ch.now_secs = '0;
        calm            = 1'b0;
        hold_replies    = 1'b0;
        clock_secs      = '0;
        key_a           = 128'h0123_4567_89ab_cdef_fedc_ba98_7654_3210;
        key_c           = 128'h5a5a_0000_ffff_1234_a5a5_8765_0000_4321;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, run with the reset lifetime of 3600 seconds.
        // Lookups in an empty table, with the zero key and with a real key.
        send_request(FUNC_VALIDATE, '0, '0, '0);
        send_request(FUNC_VALIDATE, key_a, '0, '0);
        // A create, then a lookup exactly at the expiry time, which must still succeed.
        send_request(FUNC_CREATE, key_a, '1, 32'd100);
        send_request(FUNC_VALIDATE, key_a, '0, 32'd3700);
        // Keys that match the stored one in only one half must miss.
        send_request(FUNC_VALIDATE, {key_a[KEY_W-1:HALF_W], 64'h1}, '0, 32'd100);
        send_request(FUNC_VALIDATE, {64'h1, key_a[HALF_W-1:0]}, '0, 32'd100);
        // One second late: refused and the entry is dropped, so even an early time
        // afterwards finds nothing.
        send_request(FUNC_VALIDATE, key_a, '0, 32'd3701);
        send_request(FUNC_VALIDATE, key_a, '0, 32'd100);
        // A zero key may be stored but never validates.
        send_request(FUNC_CREATE, '0, '0, '0);
        send_request(FUNC_VALIDATE, '0, '0, '0);
        // At the top of the time range the zero-key slot has expired and is reused, and
        // the new expiry saturates at the largest time.
        send_request(FUNC_CREATE, '1, 128'h8000_0000_0000_0001_8000_0000_0000_0001, TIME_MAX);
        send_request(FUNC_VALIDATE, '1, '0, TIME_MAX);
        // Duplicate keys: the lower slot answers. Once the lower copy has expired the
        // lookup is refused without looking further, and the lower copy is dropped, so an
        // early lookup then reaches the upper copy.
        send_request(FUNC_CREATE, key_c, 128'h1111_2222_3333_4444_5555_6666_7777_8888, 32'd10);
        send_request(FUNC_CREATE, key_c, 128'h9999_aaaa_bbbb_cccc_dddd_eeee_ffff_0000, 32'd10);
        send_request(FUNC_VALIDATE, key_c, '0, 32'd10);
        send_request(FUNC_VALIDATE, key_c, '0, 32'd4000);
        send_request(FUNC_VALIDATE, key_c, '0, 32'd3000);
        // Nonzero keys with one half zero behave as ordinary keys.
        send_request(FUNC_CREATE, {64'h0, 64'h5}, {rand64(), rand64()}, '0);
        send_request(FUNC_VALIDATE, {64'h0, 64'h5}, '0, '0);
        send_request(FUNC_CREATE, {64'h7, 64'h0}, {rand64(), rand64()}, '0);
        send_request(FUNC_VALIDATE, {64'h7, 64'h0}, '0, '0);
        send_request(FUNC_VALIDATE, {64'h7, 64'h0}, '0, TIME_MAX);

        // Random phases. Each starts with the table idle and a new lifetime.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_until_settled();
            create_share = 50;
            calm         = ($urandom_range(0, 3) == 0);
            case (p)
                0:
                begin
                    // Creates only, with a long lifetime, so that the table fills and reports full.
                    lifetime     = 32'd100000;
                    create_share = 100;
                    clock_secs   = 32'd10000;
                    calm         = 1'b1;
                end
                1:
                begin
                    // Jump well past the entries above; a zero lifetime lasts one second.
                    lifetime   = '0;
                    clock_secs = clock_secs + 32'd200000;
                end
                2:
                begin
                    lifetime = 32'd1;
                end
                3:
                begin
                    // The consumer stalls for a long time while requests keep coming.
                    lifetime     = 32'd50;
                    create_share = 45;
                    calm         = 1'b1;
                    hold_replies = 1'b1;
                end
                4:
                begin
                    lifetime = TIME_W'($urandom_range(2, 400));
                end
                5:
                begin
                    lifetime     = LIFETIME_RESET;
                    create_share = 55;
                end
                6:
                begin
                    lifetime     = 32'd7;
                    create_share = 40;
                end
                7:
                begin
                    // Near the top of the time range, so expiries saturate.
                    lifetime   = 32'd20;
                    clock_secs = 32'hffff_ff00;
                end
                default:
                begin
                    // Largest lifetime: every entry made now is permanent.
                    lifetime = TIME_MAX;
                end
            endcase
            set_lifetime(lifetime);
            repeat (PHASE_ITEMS)
            begin
                // Now and then the producer pauses until every reply is in.
                if ($urandom_range(0, 49) == 0)
                    wait_until_settled();
                send_random_request(create_share);
            end
        end

        // Drain, with a bound so that a missing reply is reported rather than awaited.
        req_ch.valid <= 1'b0;
        calm   = 1'b1;
        settle = 0;
        @(posedge clk);
        while (outstanding != 0 && settle < 20000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (ENTRIES + 10) @(posedge clk);
        if (outstanding != 0)
            $display("error: %0d replies never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/core/ett_pkg.sv
rtl/core/ett_if.sv
rtl/core/ett_cell.sv
rtl/core/expiring_token_table_top.sv
bench/ett_reply_checker.sv
bench/tb_top.sv
